FILE: src/jnsc_pkg.sv
// ---------------------------------------------------------------------------
// JSON number syntax check package
// Shared types, character codes and verdict codes for the number checker.
// ---------------------------------------------------------------------------
package jnsc_pkg;

   // Width of one character and of one verdict.
   localparam int CHAR_W    = 8;
   localparam int VERDICT_W = 3;

   // Characters that the start and body rules look for.
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
   localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;

   // Verdict codes; VERDICT_VALID also means "no error yet" inside a token.
   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_VALID      = 3'd0,
      VERDICT_MALFORMED  = 3'd1,
      VERDICT_LEAD_ZERO  = 3'd2,
      VERDICT_NO_DIG_SGN = 3'd3,
      VERDICT_NO_DIG_PT  = 3'd4,
      VERDICT_NO_DIG_EXP = 3'd5
   } verdict_type;

   // Position counter saturates at this value.
   localparam logic [1:0] POS_MAX = 2'd3;

   // Per-token state carried from one character to the next.
   typedef struct packed {
      logic [1:0]  char_position;
      logic        minus_first;
      logic        zero_first_digit;
      logic        point_seen;
      logic        exponent_seen;
      logic        sign_may_follow;
      logic        sign_pending_end;
      verdict_type first_error;
   } token_state_type;

   // One registered input transaction.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_char;
      logic              empty_token;
   } char_item_type;

   // Evaluation result handed to the result stage.
   typedef struct packed {
      logic        valid;
      verdict_type verdict;
   } eval_result_type;

   // True for an ASCII decimal digit.
   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

FILE: src/jnsc_if.sv
// ---------------------------------------------------------------------------
// JSON number syntax check channel interfaces
// Valid/ready channels for characters in and verdicts out.
// ---------------------------------------------------------------------------
interface jnsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [jnsc_pkg::CHAR_W-1:0]   character;
   logic                          last_char;
   logic                          empty_token;

   modport source (output valid, output character, output last_char,
                   output empty_token, input ready);
   modport sink   (input valid, input character, input last_char,
                   input empty_token, output ready);
endinterface

interface jnsc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [jnsc_pkg::VERDICT_W-1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

FILE: src/jnsc_char_eval.sv
// ---------------------------------------------------------------------------
// JSON number character evaluator
// Applies the start and body rules to one character and gives the next
// token state and, at the end of a token, its verdict.
// ---------------------------------------------------------------------------
module jnsc_char_eval (
   input  jnsc_pkg::char_item_type   item,
   input  jnsc_pkg::token_state_type state_cur,
   output jnsc_pkg::token_state_type state_nxt,
   output jnsc_pkg::eval_result_type result
);

   jnsc_pkg::token_state_type rule_st;
   jnsc_pkg::verdict_type     rule_err;
   jnsc_pkg::token_state_type step_st;
   logic                      c_digit;
   logic                      c_is_e;
   logic                      c_sign;
   logic                      body_ok;
   logic                      zero_start;

   assign c_digit = jnsc_pkg::is_digit(item.character);
   assign c_is_e  = (item.character == jnsc_pkg::CH_LOW_E) ||
                    (item.character == jnsc_pkg::CH_UP_E);
   assign c_sign  = (item.character == jnsc_pkg::CH_PLUS) ||
                    (item.character == jnsc_pkg::CH_MINUS);
   assign body_ok = c_digit ||
                    (!state_cur.point_seen && item.character == jnsc_pkg::CH_POINT) ||
                    (!state_cur.exponent_seen && c_is_e);
   assign zero_start = (item.character == jnsc_pkg::CH_ZERO) &&
                       ((state_cur.char_position == 2'd0 && !state_cur.minus_first) ||
                        (state_cur.char_position == 2'd1 && state_cur.minus_first));

   // Start rules first, then the body rule; the first rule that decides wins.
   always_comb begin
      rule_st  = state_cur;
      rule_err = jnsc_pkg::VERDICT_VALID;
      rule_st.zero_first_digit = 1'b0;
      if (state_cur.zero_first_digit && c_digit) begin
         rule_err = jnsc_pkg::VERDICT_LEAD_ZERO;
      end else if (state_cur.char_position == 2'd0 &&
                   item.character == jnsc_pkg::CH_MINUS) begin
         rule_st.minus_first = 1'b1;
         if (item.last_char) begin
            rule_err = jnsc_pkg::VERDICT_NO_DIG_SGN;
         end
      end else if (state_cur.char_position == 2'd1 && state_cur.minus_first &&
                   !c_digit) begin
         rule_err = jnsc_pkg::VERDICT_NO_DIG_SGN;
      end else if (zero_start && item.last_char) begin
         rule_err = jnsc_pkg::VERDICT_LEAD_ZERO;
      end else begin
         // A first digit zero forbids a digit right after it.
         rule_st.zero_first_digit = zero_start;
         if (state_cur.sign_may_follow && c_sign) begin
            rule_st.sign_may_follow  = 1'b0;
            rule_st.sign_pending_end = 1'b1;
            if (item.last_char) begin
               rule_err = jnsc_pkg::VERDICT_NO_DIG_SGN;
            end
         end else begin
            rule_st.sign_may_follow  = 1'b0;
            rule_st.sign_pending_end = 1'b0;
            if (!body_ok) begin
               rule_err = jnsc_pkg::VERDICT_MALFORMED;
            end else if (item.character == jnsc_pkg::CH_POINT) begin
               rule_st.point_seen = 1'b1;
               if (item.last_char) begin
                  rule_err = jnsc_pkg::VERDICT_NO_DIG_PT;
               end
            end else if (c_is_e) begin
               rule_st.exponent_seen = 1'b1;
               rule_st.point_seen    = 1'b1;
               if (item.last_char) begin
                  rule_err = jnsc_pkg::VERDICT_NO_DIG_EXP;
               end else begin
                  rule_st.sign_may_follow = 1'b1;
               end
            end
         end
      end
   end

   // Token bookkeeping: rules apply only until the first error is found.
   always_comb begin
      if (state_cur.first_error == jnsc_pkg::VERDICT_VALID) begin
         step_st             = rule_st;
         step_st.first_error = rule_err;
      end else begin
         step_st = state_cur;
      end
      if (state_cur.char_position != jnsc_pkg::POS_MAX) begin
         step_st.char_position = state_cur.char_position + 2'd1;
      end
   end

   // An empty token or a last character ends the token and clears the state.
   always_comb begin
      state_nxt      = step_st;
      result.valid   = 1'b0;
      result.verdict = step_st.first_error;
      if (item.empty_token) begin
         state_nxt      = '0;
         result.valid   = 1'b1;
         result.verdict = jnsc_pkg::VERDICT_MALFORMED;
      end else if (item.last_char) begin
         state_nxt    = '0;
         result.valid = 1'b1;
      end
   end

endmodule

FILE: src/jnsc_result_stage.sv
// ---------------------------------------------------------------------------
// JSON number result stage
// Output register that holds one verdict until the receiver takes it.
// ---------------------------------------------------------------------------
module jnsc_result_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  jnsc_pkg::verdict_type     verdict,
   output logic                      free,
   jnsc_rsp_if.source                rsp_chan
);

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   jnsc_pkg::verdict_type verdict_ff;
   jnsc_pkg::verdict_type verdict_in;

   // The register can take a new verdict when empty or being emptied now.
   assign free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         verdict_in   = verdict;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.verdict = verdict_ff;

endmodule

FILE: src/json_number_syntax_check.sv
// ---------------------------------------------------------------------------
// JSON number syntax check
// Checks a number token one character per transaction and returns a verdict.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one character of a number token per transaction, with
//   last_char marking the final character and empty_token marking an empty
//   token (its character is ignored). Only a transaction that ends a token
//   produces a transaction on rsp_chan, carrying the verdict code.
//   An ending character is held in the input register; its verdict is then
//   loaded into the result register, from which it is offered on rsp_chan.
//   Throughput is one character per cycle while no verdict waits for room in
//   the result register; the evaluator is a single pass of flag logic
//   between the input register and the result register.
//   Reset clears both registers and the token state, so a new token starts.
//   When the receiver stalls, a verdict waits in the result register while
//   characters that end no token keep flowing; an ending character holds in
//   the input register, and req_chan.ready drops, until the result register
//   frees up.
// ---------------------------------------------------------------------------
module json_number_syntax_check (
   input  logic       clock,
   input  logic       reset,
   jnsc_req_if.sink   req_chan,
   jnsc_rsp_if.source rsp_chan
);

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   jnsc_pkg::char_item_type   s1_item_ff;
   jnsc_pkg::char_item_type   s1_item_in;
   jnsc_pkg::token_state_type tok_ff;
   jnsc_pkg::token_state_type tok_in;
   jnsc_pkg::token_state_type tok_nxt;
   jnsc_pkg::eval_result_type eval_res;
   logic                      out_free;
   logic                      s1_fire;
   logic                      req_fire;

   // The registered character moves on unless its verdict finds no room.
   assign s1_fire  = s1_valid_ff && (!eval_res.valid || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_valid_in            = 1'b1;
         s1_item_in.character   = req_chan.character;
         s1_item_in.last_char   = req_chan.last_char;
         s1_item_in.empty_token = req_chan.empty_token;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Token state advances once per evaluated character.
   assign tok_in = s1_fire ? tok_nxt : tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         tok_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         tok_ff      <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   jnsc_char_eval u_char_eval (
      .item      (s1_item_ff),
      .state_cur (tok_ff),
      .state_nxt (tok_nxt),
      .result    (eval_res)
   );

   jnsc_result_stage u_result_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (s1_fire && eval_res.valid),
      .verdict  (eval_res.verdict),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: src/jnsc_checker.sv
// ---------------------------------------------------------------------------
// JSON number syntax check port checker
// Concurrent assertions on the top level's channels, bound to the top level.
// ---------------------------------------------------------------------------
module jnsc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [jnsc_pkg::VERDICT_W-1:0] rsp_verdict
);

   // Only defined verdict codes leave the block.
   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict <= jnsc_pkg::VERDICT_NO_DIG_EXP))
      else $error("verdict code out of range");

   // A stalled verdict transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("verdict withdrawn while stalled");

   // Reset empties the result register.
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict offered right after reset");

   // Reset empties the input register, so a character is taken at once.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

endmodule

bind json_number_syntax_check jnsc_checker u_jnsc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_verdict (rsp_chan.verdict)
);

FILE: tb/json_number_syntax_check_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// JSON number syntax check testbench
// Feeds number tokens one character per transaction, first from a directed
// table and then from random tokens that are mostly well formed, with random
// idle cycles on both channels. Every verdict is checked in order against the
// hand-written verdict of a fixed table row, or else against a behavioral
// model of the token rules kept inside the testbench.
module json_number_syntax_check_test;

   localparam int RANDOM_ITEMS   = 600;
   localparam int IDLE_PERCENT   = 27;
   localparam int STALL_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CALM_FIRST     = 250;
   localparam int CALM_LAST      = 400;

   // One row of the directed table; fixed rows carry a hand-written verdict.
   typedef struct {
      logic [jnsc_pkg::CHAR_W-1:0] character;
      bit                          last_char;
      bit                          empty_token;
      bit                          fixed;
      jnsc_pkg::verdict_type       verdict;
   } stim_row_type;

   // Marks that are inserted into well-formed tokens to break them.
   localparam logic [jnsc_pkg::CHAR_W-1:0] MARKS [6] = '{
      jnsc_pkg::CH_POINT, jnsc_pkg::CH_LOW_E, jnsc_pkg::CH_UP_E,
      jnsc_pkg::CH_PLUS, jnsc_pkg::CH_MINUS, jnsc_pkg::CH_ZERO};

   stim_row_type directed_rows [26] = '{
      // An empty token straight after reset.
      '{8'h00,              1'b0, 1'b1, 1'b1, jnsc_pkg::VERDICT_MALFORMED},
      // A lone zero, with and without a minus.
      '{jnsc_pkg::CH_ZERO,  1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_LEAD_ZERO},
      '{jnsc_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_ZERO,  1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_LEAD_ZERO},
      // A token that is only a minus.
      '{jnsc_pkg::CH_MINUS, 1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_NO_DIG_SGN},
      // Trailing point, trailing exponent and trailing exponent sign.
      '{"1",                1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_POINT, 1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_NO_DIG_PT},
      '{"1",                1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_LOW_E, 1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_NO_DIG_EXP},
      '{"7",                1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_UP_E,  1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_PLUS,  1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_NO_DIG_SGN},
      // A digit after a leading zero.
      '{jnsc_pkg::CH_ZERO,  1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{"1",                1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_LEAD_ZERO},
      // A minus without a digit; the characters after the error are ignored.
      '{jnsc_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{"a",                1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_MINUS, 1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_NO_DIG_SGN},
      // The highest byte is no digit and no mark.
      '{8'hFF,              1'b1, 1'b0, 1'b1, jnsc_pkg::VERDICT_MALFORMED},
      // A full number with a signed exponent.
      '{"9",                1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_UP_E,  1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{jnsc_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{"7",                1'b1, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      // An empty token drops an unfinished one and ignores its other fields.
      '{"5",                1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{8'hFF,              1'b1, 1'b1, 1'b1, jnsc_pkg::VERDICT_MALFORMED},
      // A leading point is accepted.
      '{jnsc_pkg::CH_POINT, 1'b0, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID},
      '{"5",                1'b1, 1'b0, 1'b0, jnsc_pkg::VERDICT_VALID}
   };

   logic clock;
   logic reset;
   bit   calm;
   int   errors;
   int   items_sent;
   int   quiet_cycles;

   jnsc_pkg::token_state_type token;
   jnsc_pkg::verdict_type     expected_verdicts [$];

   jnsc_req_if req_chan ();
   jnsc_rsp_if rsp_chan ();

   json_number_syntax_check dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Free-running clock, 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
   endtask

   // Applies one character to the token model; returns 1 when a verdict is due.
   function automatic bit predict_verdict(input jnsc_pkg::char_item_type item,
                                          output jnsc_pkg::verdict_type verdict);
      logic [jnsc_pkg::CHAR_W-1:0] c;
      logic [1:0]                  pos;
      bit                          digit;
      bit                          is_e;
      bit                          lead_position;
      bit                          zero_before;
      jnsc_pkg::verdict_type       found;

      c     = item.character;
      pos   = token.char_position;
      digit = (c >= jnsc_pkg::CH_ZERO) && (c <= jnsc_pkg::CH_NINE);
      is_e  = (c == jnsc_pkg::CH_LOW_E) || (c == jnsc_pkg::CH_UP_E);
      found = jnsc_pkg::VERDICT_VALID;
      verdict = jnsc_pkg::VERDICT_VALID;

      if (item.empty_token) begin
         token = '0;
         verdict = jnsc_pkg::VERDICT_MALFORMED;
         return 1'b1;
      end

      // Once an error is recorded, the rest of the token is skipped.
      if (token.first_error == jnsc_pkg::VERDICT_VALID) begin
         zero_before = token.zero_first_digit;
         token.zero_first_digit = 1'b0;
         lead_position = (pos == 2'd0 && !token.minus_first) ||
                         (pos == 2'd1 && token.minus_first);
         if (zero_before && digit) begin
            found = jnsc_pkg::VERDICT_LEAD_ZERO;
         end else if (pos == 2'd0 && c == jnsc_pkg::CH_MINUS) begin
            token.minus_first = 1'b1;
            if (item.last_char) found = jnsc_pkg::VERDICT_NO_DIG_SGN;
         end else if (pos == 2'd1 && token.minus_first && !digit) begin
            found = jnsc_pkg::VERDICT_NO_DIG_SGN;
         end else if (lead_position && c == jnsc_pkg::CH_ZERO && item.last_char) begin
            found = jnsc_pkg::VERDICT_LEAD_ZERO;
         end else begin
            if (lead_position && c == jnsc_pkg::CH_ZERO) token.zero_first_digit = 1'b1;
            // One sign right after the exponent mark is skipped.
            if (token.sign_may_follow &&
                (c == jnsc_pkg::CH_PLUS || c == jnsc_pkg::CH_MINUS)) begin
               token.sign_may_follow  = 1'b0;
               token.sign_pending_end = 1'b1;
               if (item.last_char) found = jnsc_pkg::VERDICT_NO_DIG_SGN;
            end else begin
               token.sign_may_follow  = 1'b0;
               token.sign_pending_end = 1'b0;
               if (!(digit || (!token.point_seen && c == jnsc_pkg::CH_POINT) ||
                     (!token.exponent_seen && is_e))) begin
                  found = jnsc_pkg::VERDICT_MALFORMED;
               end else if (c == jnsc_pkg::CH_POINT) begin
                  token.point_seen = 1'b1;
                  if (item.last_char) found = jnsc_pkg::VERDICT_NO_DIG_PT;
               end else if (is_e) begin
                  token.exponent_seen = 1'b1;
                  token.point_seen    = 1'b1;
                  if (item.last_char) found = jnsc_pkg::VERDICT_NO_DIG_EXP;
                  else token.sign_may_follow = 1'b1;
               end
            end
         end
         token.first_error = found;
      end

      if (token.char_position != jnsc_pkg::POS_MAX) token.char_position++;
      if (!item.last_char) return 1'b0;
      verdict = token.first_error;
      token = '0;
      return 1'b1;
   endfunction

   // Offers one character transaction and records the verdict it will cause.
   task automatic send_item(input jnsc_pkg::char_item_type item, input bit fixed,
                            input jnsc_pkg::verdict_type fixed_verdict);
      jnsc_pkg::verdict_type verdict;

      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.character   <= item.character;
      req_chan.last_char   <= item.last_char;
      req_chan.empty_token <= item.empty_token;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (predict_verdict(item, verdict))
         expected_verdicts.push_back(fixed ? fixed_verdict : verdict);
   endtask

   // Receiver side: random stalls outside the calm stretch.
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Each verdict transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0d with no token pending",
                                      rsp_chan.verdict));
         end else begin
            if (rsp_chan.verdict !== expected_verdicts[0])
               report_mismatch($sformatf("verdict %0d, expected %0d",
                                         rsp_chan.verdict, expected_verdicts[0]));
            void'(expected_verdicts.pop_front());
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("json_number_syntax_check: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed table, then random tokens.
   initial begin : stimulus
      jnsc_pkg::char_item_type     item;
      logic [jnsc_pkg::CHAR_W-1:0] chars [$];
      int                          roll;
      int                          n;

      errors       = 0;
      items_sent   = 0;
      quiet_cycles = 0;
      calm         = 1'b0;
      token        = '0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.character   = '0;
      req_chan.last_char   = 1'b0;
      req_chan.empty_token = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         item.character   = directed_rows[i].character;
         item.last_char   = directed_rows[i].last_char;
         item.empty_token = directed_rows[i].empty_token;
         send_item(item, directed_rows[i].fixed, directed_rows[i].verdict);
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
         chars.delete();
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // Empty token, sometimes cutting off a few digits.
            repeat ($urandom_range(0, 3))
               chars.push_back(8'(jnsc_pkg::CH_ZERO + $urandom_range(0, 9)));
            foreach (chars[k])
               send_item('{chars[k], 1'b0, 1'b0}, 1'b0, jnsc_pkg::VERDICT_VALID);
            send_item('{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1},
                      1'b0, jnsc_pkg::VERDICT_VALID);
         end else begin
            if (roll < 16) begin
               // Noise: random bytes.
               repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(0, 255)));
            end else begin
               // Well-formed number with random content.
               if ($urandom_range(0, 1)) chars.push_back(jnsc_pkg::CH_MINUS);
               if ($urandom_range(0, 3) == 0) begin
                  chars.push_back(jnsc_pkg::CH_ZERO);
               end else begin
                  chars.push_back(8'(jnsc_pkg::CH_ZERO + $urandom_range(1, 9)));
                  repeat ($urandom_range(0, 3))
                     chars.push_back(8'(jnsc_pkg::CH_ZERO + $urandom_range(0, 9)));
               end
               if ($urandom_range(0, 2) == 0) begin
                  chars.push_back(jnsc_pkg::CH_POINT);
                  repeat ($urandom_range(1, 3))
                     chars.push_back(8'(jnsc_pkg::CH_ZERO + $urandom_range(0, 9)));
               end
               if ($urandom_range(0, 2) == 0) begin
                  chars.push_back($urandom_range(0, 1) ? jnsc_pkg::CH_LOW_E
                                                       : jnsc_pkg::CH_UP_E);
                  n = $urandom_range(0, 2);
                  if (n == 1) chars.push_back(jnsc_pkg::CH_PLUS);
                  if (n == 2) chars.push_back(jnsc_pkg::CH_MINUS);
                  repeat ($urandom_range(1, 2))
                     chars.push_back(8'(jnsc_pkg::CH_ZERO + $urandom_range(0, 9)));
               end
               if ($urandom_range(0, 19) == 0)
                  chars.push_front($urandom_range(0, 1) ? jnsc_pkg::CH_POINT
                                                        : jnsc_pkg::CH_LOW_E);
               // Break about a quarter of the tokens.
               if ($urandom_range(0, 99) < 25) begin
                  case ($urandom_range(0, 2))
                     0: begin
                        chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
                     end
                     1: begin
                        n = $urandom_range(1, chars.size());
                        while (chars.size() > n) void'(chars.pop_back());
                     end
                     default: begin
                        chars.insert($urandom_range(0, chars.size()),
                                     MARKS[$urandom_range(0, 5)]);
                     end
                  endcase
               end
            end
            foreach (chars[k])
               send_item('{chars[k], 1'(k == chars.size() - 1), 1'b0}, 1'b0,
                         jnsc_pkg::VERDICT_VALID);
         end
      end

      // Drain the remaining verdicts, then allow for the pipeline depth.
      req_chan.valid <= 1'b0;
      calm = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("json_number_syntax_check: match");
      end else begin
         $display("json_number_syntax_check: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/jnsc_pkg.sv
src/jnsc_if.sv
src/jnsc_char_eval.sv
src/jnsc_result_stage.sv
src/json_number_syntax_check.sv
src/jnsc_checker.sv
tb/json_number_syntax_check_test.sv
